FILE: sv/nds_pkg.sv
// ============================================================================
// nds_pkg: shared types and constants for the nth difference sum unit
// Register map, field widths, row-builder status and the coefficient width
// function used to size the signed binomial row.
// ============================================================================
package nds_pkg;

    // Default sizing
    localparam int NDS_MAX_ORDER   = 15;
    localparam int NDS_SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int ORDER_W = 4;
    localparam int TOTAL_W = 48;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0]         REG_IDX_ORDER = 1'b0;
    localparam logic [ORDER_W-1:0] ORDER_RESET   = 4'd1;

    // Status of the coefficient row builder
    typedef struct packed {
        logic busy;
        logic done;
    } t_row_stat;

    // Signed width that holds every coefficient of rows 0..max_order
    function automatic int f_coef_bits(input int max_order);
        longint pas [0:31];
        longint peak;
        int     bits;
        int     r;
        int     k;
        for (k = 0; k < 32; k++) begin
            pas[k] = 0;
        end
        pas[0] = 1;
        peak   = 1;
        for (r = 1; r <= max_order; r++) begin
            for (k = r; k >= 1; k--) begin
                pas[k] = pas[k] + pas[k-1];
                if (pas[k] > peak) begin
                    peak = pas[k];
                end
            end
        end
        bits = 2;
        while ((longint'(1) << (bits - 1)) <= peak) begin
            bits++;
        end
        return bits;
    endfunction

endpackage

FILE: sv/nds_in_if.sv
// ============================================================================
// nds_in_if: sample channel
// Valid/ready channel carrying one signed sample and its end-of-sequence flag.
// ============================================================================
interface nds_in_if
    import nds_pkg::*;
#(
    parameter int SAMPLE_BITS = NDS_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: sv/nds_out_if.sv
// ============================================================================
// nds_out_if: result channel
// Valid/ready channel carrying the sequence total and its done marker.
// ============================================================================
interface nds_out_if
    import nds_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [TOTAL_W-1:0] total;
    logic                      done_res;

    modport source (output valid, output total, output done_res, input ready);
    modport sink   (input valid, input total, input done_res, output ready);
endinterface

FILE: sv/nth_difference_sum_unit.sv
// ============================================================================
// nth_difference_sum_unit: sum of a sequence after n differencing rounds
// Window, shared multiply-accumulate sequencer, output register and APB port.
// ============================================================================
// The unit takes one signed sample per transfer and sums the order-th forward
// difference (newest minus oldest sign convention) of every full window of
// order+1 samples; the sample flagged last returns the 48-bit wrapped total
// and starts a fresh sequence. Order is written over APB at address 0 and is
// latched at the first sample of each sequence. With n the latched order, a
// sample whose window is full passes accept, shift, a step of the one shared
// multiplier for each of the n+1 coefficients, drain and finish; a sample
// that only fills the window passes accept, shift and finish. The first sample
// of a sequence also builds the coefficient row on the single subtractor of the
// row builder. The next sample is taken only once the current one is done;
// a finished total waits in the output register without blocking input,
// except when another total is ready before the first is taken.
module nth_difference_sum_unit
    import nds_pkg::*;
#(
    parameter int MAX_ORDER   = NDS_MAX_ORDER,
    parameter int SAMPLE_BITS = NDS_SAMPLE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    nds_in_if.sink              i_in,
    nds_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);
    localparam int DEPTH  = MAX_ORDER + 1;
    localparam int ORD_W  = $clog2(DEPTH);
    localparam int SEEN_W = $clog2(DEPTH + 1);
    localparam int COEF_W = f_coef_bits(MAX_ORDER);
    localparam int PROD_W = COEF_W + SAMPLE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SHIFT,
        ST_MAC,
        ST_DRAIN,
        ST_FIN
    } t_state;

    t_state                        r_state;
    logic [ORDER_W-1:0]            r_order;
    logic [ORD_W-1:0]              r_active;
    logic [SEEN_W-1:0]             r_seen;
    logic [ORD_W-1:0]              r_k;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;
    logic signed [SAMPLE_BITS-1:0] r_window [DEPTH];
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_pvalid;
    logic signed [TOTAL_W-1:0]     r_acc;
    logic signed [TOTAL_W-1:0]     r_total;
    logic                          r_out_valid;

    logic                          w_accept;
    logic                          w_row_start;
    logic [ORD_W-1:0]              w_order_sat;
    logic signed [COEF_W-1:0]      w_coef;
    t_row_stat                     w_row_stat;
    logic [SEEN_W-1:0]             w_full_cnt;
    logic [SEEN_W-1:0]             n_seen;
    logic                          w_out_free;
    logic                          w_cfg_wr;
    logic signed [SAMPLE_BITS-1:0] w_upper [DEPTH];

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[PADDR_W-1:2] == REG_IDX_ORDER) ? PDATA_W'(r_order) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (w_cfg_wr && (paddr[PADDR_W-1:2] == REG_IDX_ORDER)) begin
            r_order <= pwdata[ORDER_W-1:0];
        end
    end

    // Handshake and sequence-start decode
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_row_start = w_accept && (r_seen == '0);
    assign w_order_sat = (int'(r_order) > MAX_ORDER) ? ORD_W'(MAX_ORDER)
                                                     : ORD_W'(r_order);

    // Window fill count, saturating at order+1
    assign w_full_cnt = SEEN_W'(r_active) + 1'b1;
    assign n_seen     = (r_seen == w_full_cnt) ? r_seen : r_seen + 1'b1;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Upper neighbor of each window tap
    for (genvar g = 0; g < DEPTH; g++) begin : g_upper
        if (g == DEPTH - 1) begin : g_top
            assign w_upper[g] = '0;
        end else begin : g_mid
            assign w_upper[g] = r_window[g+1];
        end
    end

    // Coefficient row
    nds_row #(
        .MAX_ORDER (MAX_ORDER),
        .COEF_W    (COEF_W)
    ) u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_row_start),
        .i_order  (w_order_sat),
        .i_rd_idx (r_k),
        .o_coef   (w_coef),
        .o_stat   (w_row_stat)
    );

    // Sequencer, window, shared MAC and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_seen      <= '0;
            r_k         <= '0;
            r_last      <= 1'b0;
            r_pvalid    <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_window[i] <= '0;
            end
        end else begin
            // Load a finished total, else drop a taken result
            if (r_state == ST_FIN && r_last && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // Add the product of the previous step
            if (r_pvalid) begin
                r_acc <= r_acc + TOTAL_W'(r_prod);
            end
            r_pvalid <= (r_state == ST_MAC);

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_sample <= i_in.sample;
                        r_last   <= i_in.last;
                        if (r_seen == '0) begin
                            r_active <= w_order_sat;
                            r_state  <= ST_BUILD;
                        end else begin
                            r_state <= ST_SHIFT;
                        end
                    end
                end
                ST_BUILD: begin
                    if (w_row_stat.done) begin
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (ORD_W'(i) < r_active) begin
                            r_window[i] <= w_upper[i];
                        end else if (ORD_W'(i) == r_active) begin
                            r_window[i] <= r_sample;
                        end
                    end
                    r_seen <= n_seen;
                    r_k    <= '0;
                    if (n_seen == w_full_cnt) begin
                        r_state <= ST_MAC;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_MAC: begin
                    r_prod <= w_coef * r_window[r_k];
                    if (r_k == r_active) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        // Hand over the total and clear the sequence
                        r_total <= r_acc;
                        r_acc   <= '0;
                        r_seen  <= '0;
                        for (int i = 0; i < DEPTH; i++) begin
                            r_window[i] <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.total    = r_total;
    assign o_out.done_res = 1'b1;

    // Checks
    a_clear_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_last && w_out_free) |=> (r_acc == '0 && r_seen == '0))
        else $error("sequence state not cleared after a result");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= w_full_cnt)
        else $error("fill count beyond order+1");

    a_mac_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_k <= r_active))
        else $error("MAC index beyond active order");

    a_row_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_row_stat.busy)
        else $error("sample taken while row is being built");

endmodule

FILE: sv/nds_row.sv
// ============================================================================
// nds_row: signed binomial row builder
// Builds the coefficients of (x - 1)^n by n rounds of c[k] = c[k-1] - c[k],
// one subtraction per cycle while the row rotates through a single slot.
// ============================================================================
module nds_row
    import nds_pkg::*;
#(
    parameter int MAX_ORDER = NDS_MAX_ORDER,
    parameter int COEF_W    = f_coef_bits(NDS_MAX_ORDER)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [$clog2(MAX_ORDER+1)-1:0]         i_order,
    input  logic [$clog2(MAX_ORDER+1)-1:0]         i_rd_idx,
    output logic signed [COEF_W-1:0]               o_coef,
    output t_row_stat                              o_stat
);
    localparam int DEPTH = MAX_ORDER + 1;
    localparam int ORD_W = $clog2(DEPTH);

    logic signed [COEF_W-1:0] r_row [DEPTH];
    logic signed [COEF_W-1:0] r_prev;
    logic [ORD_W-1:0]         r_pos;
    logic [ORD_W-1:0]         r_round;
    logic [ORD_W-1:0]         r_order;
    logic                     r_busy;
    logic                     r_done;
    logic signed [COEF_W-1:0] w_new;

    // One shared subtractor: previous entry minus the entry at the head
    assign w_new = r_prev - r_row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_pos   <= '0;
            r_round <= '0;
            r_order <= '0;
            r_prev  <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_row[i] <= '0;
            end
        end else begin
            if (i_start) begin
                // Seed with row zero
                for (int i = 0; i < DEPTH; i++) begin
                    r_row[i] <= (i == 0) ? COEF_W'(1) : '0;
                end
                r_order <= i_order;
                r_pos   <= '0;
                r_round <= ORD_W'(1);
                r_prev  <= '0;
                if (i_order == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                end
            end else if (r_busy) begin
                // Rotate: head leaves, new entry enters at the tail
                for (int i = 0; i < DEPTH - 1; i++) begin
                    r_row[i] <= r_row[i+1];
                end
                r_row[DEPTH-1] <= w_new;
                if (r_pos == ORD_W'(DEPTH - 1)) begin
                    r_pos  <= '0;
                    r_prev <= '0;
                    if (r_round == r_order) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_round <= r_round + 1'b1;
                        r_done  <= 1'b0;
                    end
                end else begin
                    r_pos  <= r_pos + 1'b1;
                    r_prev <= r_row[0];
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_coef      = r_row[i_rd_idx];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
